### hw/rtl/rpn_pkg.sv
// ----------------------------------------------------------------------------
// rpn_pkg
// Shared types and codes of the stack calculator.
// ----------------------------------------------------------------------------
package rpn_pkg;

  localparam int unsigned CmdW = 3;
  localparam int unsigned ValW = 32;

  typedef enum logic [2:0] {
    CMD_PUSH = 3'd0,
    CMD_ADD  = 3'd1,
    CMD_SUB  = 3'd2,
    CMD_MUL  = 3'd3,
    CMD_DIV  = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD1,
    S_RD2,
    S_EXEC,
    S_MUL,
    S_DIV,
    S_WRITE,
    S_TOP_RD,
    S_TOP_WAIT,
    S_OUT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic       load;       // capture request
    logic       rd_top;     // read slot at pointer
    logic       rd_next;    // read slot at pointer - 1
    logic       cap_a;      // capture read data as first operand
    logic       cap_b;      // capture read data as second operand
    logic       do_alu;     // add, subtract or set up mul / div
    logic       mul_step;   // register product result
    logic       div_start;
    logic       wr_push;    // write push value at pointer + 1
    logic       wr_res;     // write result at pointer - 1
    logic       ptr_inc;
    logic       ptr_dec;
    logic       ptr_zero;
    logic       set_status;
    status_e    status;
    logic       cap_top;    // capture read data as top value
    logic       top_zero;
  } ctrl_t;

  // datapath to controller
  typedef struct packed {
    cmd_e cmd;
    logic cmd_valid;
    logic ptr_is_zero;
    logic ptr_is_one;
    logic ptr_full;
    logic div_done;
  } stat_t;

endpackage

### hw/rtl/rpn_if.sv
// ----------------------------------------------------------------------------
// rpn_req_if / rpn_rsp_if
// Valid / ready channels of the stack calculator.
// ----------------------------------------------------------------------------
interface rpn_req_if;
  logic                valid;
  logic                ready;
  logic [2:0]          cmd;
  logic signed [31:0]  push_value;
  modport source (output valid, cmd, push_value, input ready);
  modport sink   (input valid, cmd, push_value, output ready);
endinterface

interface rpn_rsp_if;
  logic                valid;
  logic                ready;
  logic [1:0]          status;
  logic                saturated;
  logic [7:0]          depth_now;
  logic signed [31:0]  top_value;
  modport source (output valid, status, saturated, depth_now, top_value, input ready);
  modport sink   (input valid, status, saturated, depth_now, top_value, output ready);
endinterface

### hw/rtl/rpn_ram.sv
// ----------------------------------------------------------------------------
// rpn_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module rpn_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  // registered read, old data returned on a write
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

### hw/rtl/rpn_div.sv
// ----------------------------------------------------------------------------
// rpn_div
// Restoring divider, one quotient bit per cycle, for (a * 65536) / b.
// ----------------------------------------------------------------------------
module rpn_div (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [31:0] a,
  input  logic signed [31:0] b,
  output logic               done,
  output logic signed [31:0] q,
  output logic               sat
);
  import rpn_pkg::*;

  logic [47:0] dvd;       // magnitude of dividend, shifted out msb first
  logic [31:0] dvs;
  logic [32:0] rem;
  logic [47:0] quo;
  logic [5:0]  cnt;
  logic        busy;
  logic        neg;
  logic [33:0] trial;
  logic [32:0] rem_sh;
  logic [48:0] sq;

  assign rem_sh = {rem[31:0], dvd[47]};
  assign trial  = {1'b0, rem_sh} - {2'b00, dvs};

  // iterate over 48 dividend bits
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 6'd47;
        dvd  <= {(a[31] ? 32'(-a) : 32'(a)), 16'h0};
        dvs  <= b[31] ? 32'(-b) : 32'(b);
        neg  <= a[31] ^ b[31];
        rem  <= '0;
      end else if (busy) begin
        dvd <= {dvd[46:0], 1'b0};
        if (!trial[33]) begin
          rem <= trial[32:0];
          quo <= {quo[46:0], 1'b1};
        end else begin
          rem <= rem_sh;
          quo <= {quo[46:0], 1'b0};
        end
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        cnt <= cnt - 6'd1;
      end
    end
  end

  // sign, saturation
  always_comb begin
    sq = neg ? -{1'b0, quo} : {1'b0, quo};
    if (!neg && quo > 48'h7FFF_FFFF) begin
      q = 32'sh7FFF_FFFF; sat = 1'b1;
    end else if (neg && quo > 48'h8000_0000) begin
      q = 32'sh8000_0000; sat = 1'b1;
    end else begin
      q = sq[31:0]; sat = 1'b0;
    end
  end
endmodule

### hw/rtl/rpn_dp.sv
// ----------------------------------------------------------------------------
// rpn_dp
// Datapath: stack memory, pointer, operands, arithmetic and result register.
// ----------------------------------------------------------------------------
module rpn_dp #(
  parameter int unsigned StackDepth = 256
) (
  input  logic                  clk,
  input  logic                  rst,
  input  rpn_pkg::ctrl_t        ctrl,
  output rpn_pkg::stat_t        stat,
  input  logic [2:0]            in_cmd,
  input  logic signed [31:0]    in_value,
  output logic [1:0]            status,
  output logic                  saturated,
  output logic [7:0]            depth_now,
  output logic signed [31:0]    top_value
);
  import rpn_pkg::*;

  localparam int unsigned AW = $clog2(StackDepth);

  logic [AW-1:0]      ptr;
  logic [2:0]         cmd;
  logic signed [31:0] pval;
  logic signed [31:0] opa, opb, res;
  logic               res_sat;
  logic               we;
  logic [AW-1:0]      addr;
  logic [31:0]        wdata, rdata;
  logic signed [63:0] prod;
  logic signed [32:0] sum;
  logic signed [47:0] mq;
  logic signed [31:0] dq;
  logic               dsat, ddone;

  rpn_ram #(.Width(ValW), .Depth(StackDepth)) u_ram (
    .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
  );

  rpn_div u_div (
    .clk(clk), .rst(rst), .start(ctrl.div_start), .a(opa), .b(opb),
    .done(ddone), .q(dq), .sat(dsat)
  );

  // memory address and write selection
  always_comb begin
    we    = ctrl.wr_push | ctrl.wr_res;
    wdata = ctrl.wr_push ? pval : res;
    if (ctrl.wr_push) addr = ptr + AW'(1);
    else if (ctrl.wr_res || ctrl.rd_next) addr = ptr - AW'(1);
    else addr = ptr;
  end

  // slots at or below a non-zero pointer are always written before being read
  logic [31:0] rd_eff;
  assign rd_eff = rdata;

  // pointer and request capture
  always_ff @(posedge clk) begin
    if (rst) begin
      ptr <= '0;
    end else if (ctrl.ptr_inc) begin
      ptr <= ptr + AW'(1);
    end else if (ctrl.ptr_dec) begin
      ptr <= ptr - AW'(1);
    end else if (ctrl.ptr_zero) begin
      ptr <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      cmd  <= in_cmd;
      pval <= in_value;
    end
    if (ctrl.cap_a) opa <= rd_eff;
    if (ctrl.cap_b) opb <= rd_eff;
  end

  assign sum = (cmd == CMD_SUB) ? (33'(opa) - 33'(opb)) : (33'(opa) + 33'(opb));

  // multiply registered, then shift with floor and saturate
  always_ff @(posedge clk) begin
    if (ctrl.do_alu) prod <= opa * opb;
  end
  assign mq = prod[63:16];

  // result register
  always_ff @(posedge clk) begin
    if (ctrl.do_alu) begin
      res_sat <= 1'b0;
      if (cmd == CMD_ADD || cmd == CMD_SUB) begin
        if (sum > 33'sh0_7FFF_FFFF) begin
          res <= 32'sh7FFF_FFFF; res_sat <= 1'b1;
        end else if (sum < -33'sh0_8000_0000) begin
          res <= 32'sh8000_0000; res_sat <= 1'b1;
        end else begin
          res <= sum[31:0];
        end
      end else if (cmd == CMD_DIV && opb == 0) begin
        res_sat <= 1'b1;
        res <= (opa > 0) ? 32'sh7FFF_FFFF : ((opa < 0) ? 32'sh8000_0000 : 32'sh0);
      end
    end else if (ctrl.mul_step) begin
      if (mq > 48'sh7FFF_FFFF) begin
        res <= 32'sh7FFF_FFFF; res_sat <= 1'b1;
      end else if (mq < -48'sh8000_0000) begin
        res <= 32'sh8000_0000; res_sat <= 1'b1;
      end else begin
        res <= mq[31:0];
      end
    end else if (ddone && opb != 0) begin
      // a zero divisor keeps the value set above
      res <= dq; res_sat <= dsat;
    end
  end

  // output fields
  always_ff @(posedge clk) begin
    if (ctrl.load) saturated <= 1'b0;
    else if (ctrl.wr_res) saturated <= res_sat;
    if (ctrl.set_status) status <= ctrl.status;
    if (ctrl.cap_top) top_value <= rd_eff;
    else if (ctrl.top_zero) top_value <= '0;
  end
  assign depth_now = 8'(ptr);

  always_comb begin
    stat.cmd         = cmd_e'(cmd);
    stat.cmd_valid   = (cmd <= 3'(CMD_DIV));
    stat.ptr_is_zero = (ptr == '0);
    stat.ptr_is_one  = (ptr == AW'(1));
    stat.ptr_full    = (ptr == AW'(StackDepth - 1));
    stat.div_done    = ddone;
  end
endmodule

### hw/rtl/rpn_ctrl.sv
// ----------------------------------------------------------------------------
// rpn_ctrl
// Controller: sequences one request through read, execute, write and reply.
// ----------------------------------------------------------------------------
module rpn_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  rpn_pkg::stat_t stat,
  output rpn_pkg::ctrl_t ctrl
);
  import rpn_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  // next state and commands
  always_comb begin
    ctrl       = '0;
    ctrl.status = ST_OK;
    state_next = state;
    in_ready   = (state == S_IDLE);
    out_valid  = (state == S_OUT);
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          ctrl.load  = 1'b1;
          state_next = S_RD1;
        end
      end
      S_RD1: begin
        ctrl.set_status = 1'b1;
        if (stat.cmd == CMD_PUSH) begin
          if (stat.ptr_full) begin
            ctrl.status = ST_OVERFLOW;
          end else begin
            ctrl.wr_push = 1'b1;
            ctrl.ptr_inc = 1'b1;
          end
          state_next = S_TOP_RD;
        end else if (!stat.cmd_valid) begin
          state_next = S_TOP_RD;
        end else if (stat.ptr_is_zero || stat.ptr_is_one) begin
          ctrl.status   = ST_UNDERFLOW;
          ctrl.ptr_zero = 1'b1;
          state_next    = S_TOP_RD;
        end else begin
          ctrl.rd_top = 1'b1;
          state_next  = S_RD2;
        end
      end
      S_RD2: begin
        ctrl.cap_a   = 1'b1;
        ctrl.rd_next = 1'b1;
        state_next   = S_EXEC;
      end
      S_EXEC: begin
        ctrl.cap_b = 1'b1;
        state_next = S_MUL;
      end
      S_MUL: begin
        ctrl.do_alu = 1'b1;
        if (stat.cmd == CMD_MUL) begin
          state_next = S_DIV;
        end else if (stat.cmd == CMD_DIV) begin
          ctrl.div_start = 1'b1;
          state_next     = S_DIV;
        end else begin
          state_next = S_WRITE;
        end
      end
      S_DIV: begin
        if (stat.cmd == CMD_MUL) begin
          ctrl.mul_step = 1'b1;
          state_next    = S_WRITE;
        end else if (stat.div_done) begin
          state_next = S_WRITE;
        end
      end
      S_WRITE: begin
        ctrl.wr_res  = 1'b1;
        ctrl.ptr_dec = 1'b1;
        state_next   = S_TOP_RD;
      end
      S_TOP_RD: begin
        ctrl.rd_top = 1'b1;
        state_next  = S_TOP_WAIT;
      end
      S_TOP_WAIT: begin
        if (stat.ptr_is_zero) ctrl.top_zero = 1'b1;
        else                  ctrl.cap_top  = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (out_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // reply held until taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid) else $error("reply dropped");
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid)) else $error("request taken during reply");
  a_one_write: assert property (@(posedge clk) disable iff (rst)
    !(ctrl.wr_push && ctrl.wr_res)) else $error("two stack writes");
endmodule

### hw/rtl/rpn_stack_calculator.sv
// ----------------------------------------------------------------------------
// rpn_stack_calculator
// Q16.16 reverse polish calculator with stack in RAM.
// Push, unused codes and stack errors go from S_RD1 to S_TOP_RD; add and
// subtract also pass S_RD2, S_EXEC, S_MUL, S_WRITE; multiply adds S_DIV, where
// divide waits on the one-bit-per-cycle divider over 48 dividend bits. One
// request in flight at a time; the next is taken in the cycle after the reply.
// Reset (rst, synchronous): pointer cleared; slots are written before read.
// ----------------------------------------------------------------------------
module rpn_stack_calculator #(
  parameter int unsigned STACK_DEPTH = 256
) (
  input logic        clk,
  input logic        rst,
  rpn_req_if.sink    req,
  rpn_rsp_if.source  rsp
);
  import rpn_pkg::*;

  ctrl_t ctrl;
  stat_t stat;

  rpn_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(req.valid), .in_ready(req.ready),
    .out_valid(rsp.valid), .out_ready(rsp.ready),
    .stat(stat), .ctrl(ctrl)
  );

  rpn_dp #(.StackDepth(STACK_DEPTH)) u_dp (
    .clk(clk), .rst(rst), .ctrl(ctrl), .stat(stat),
    .in_cmd(req.cmd), .in_value(req.push_value),
    .status(rsp.status), .saturated(rsp.saturated),
    .depth_now(rsp.depth_now), .top_value(rsp.top_value)
  );
endmodule

### test/rpn_tb_if.sv
// ----------------------------------------------------------------------------
// rpn_tb_if
// Testbench package: the expected reply record. The request and reply
// channels come from the RTL interfaces.
// ----------------------------------------------------------------------------
package rpn_tb_pkg;
  import rpn_pkg::*;

  // one expected reply
  typedef struct packed {
    status_e            status;
    logic               saturated;
    logic [7:0]         depth_now;
    logic signed [31:0] top_value;
  } reply_t;
endpackage

### test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Stack calculator check: directed and random commands are driven over the
// request channel. A behavioural stack model predicts every reply, and each
// reply is compared field by field in arrival order.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import rpn_pkg::*;
  import rpn_tb_pkg::*;

  localparam int Depth = 256;
  localparam int HoldLen = 400;
  localparam logic signed [31:0] QMax = 32'sh7FFFFFFF;
  localparam logic signed [31:0] QMin = 32'sh80000000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  rpn_req_if req ();
  rpn_rsp_if rsp ();

  rpn_stack_calculator #(.STACK_DEPTH(Depth)) dut (
    .clk(clk), .rst(rst), .req(req.sink), .rsp(rsp.source)
  );

  // model state
  logic signed [31:0] calc_stack [Depth];
  int unsigned        calc_ptr;
  reply_t             pending_replies [$];

  int  send_idle_pct;
  int  recv_idle_pct;
  int  hold_cycles;
  bit  hold_req;
  bit  hold_taken;
  bit  failed = 1'b0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // clamp a wide result into Q16.16
  function automatic logic signed [31:0] clamp_q(input logic signed [63:0] v,
                                                 inout logic sat);
    if (v > 64'sh7FFFFFFF) begin
      sat = 1'b1;
      return QMax;
    end
    if (v < -64'sh80000000) begin
      sat = 1'b1;
      return QMin;
    end
    return v[31:0];
  endfunction

  // arithmetic of one binary command on first (top) and second
  function automatic logic signed [31:0] apply_op(input logic [2:0] op,
      input logic signed [31:0] a, input logic signed [31:0] b, inout logic sat);
    logic signed [63:0] x;
    logic signed [63:0] y;
    logic signed [63:0] p;
    x = a;
    y = b;
    case (op)
      CMD_ADD: return clamp_q(x + y, sat);
      CMD_SUB: return clamp_q(x - y, sat);
      CMD_MUL: begin
        p = x * y;
        return clamp_q(p >>> 16, sat);
      end
      default: begin
        if (y == 0) begin
          sat = 1'b1;
          if (x > 0) return QMax;
          if (x < 0) return QMin;
          return 32'sd0;
        end
        return clamp_q((x * 64'sd65536) / y, sat);
      end
    endcase
  endfunction

  // advance the model by one request and queue its reply
  task automatic predict_reply(input logic [2:0] cmd, input logic signed [31:0] val);
    reply_t r;
    logic sat;
    sat = 1'b0;
    r.status = ST_OK;
    if (cmd == CMD_PUSH) begin
      if (calc_ptr >= Depth - 1) r.status = ST_OVERFLOW;
      else begin
        calc_ptr++;
        calc_stack[calc_ptr] = val;
      end
    end else if (cmd <= CMD_DIV) begin
      if (calc_ptr == 0) r.status = ST_UNDERFLOW;
      else if (calc_ptr == 1) begin
        calc_ptr = 0;
        r.status = ST_UNDERFLOW;
      end else begin
        calc_stack[calc_ptr - 1] = apply_op(cmd, calc_stack[calc_ptr],
                                            calc_stack[calc_ptr - 1], sat);
        calc_ptr--;
      end
    end
    r.saturated = sat;
    r.depth_now = calc_ptr[7:0];
    r.top_value = calc_stack[calc_ptr];
    pending_replies.push_back(r);
  endtask

  // drive one request, with random idle before it; valid stays up until
  // the next request or an idle cycle replaces it
  task automatic send_cmd(input logic [2:0] cmd, input logic signed [31:0] val);
    while ($urandom_range(99) < send_idle_pct) begin
      req.valid <= 1'b0;
      @(negedge clk);
    end
    req.valid <= 1'b1;
    req.cmd <= cmd;
    req.push_value <= val;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    predict_reply(cmd, val);
    @(negedge clk);
  endtask

  function automatic logic signed [31:0] rand_value();
    case ($urandom_range(5))
      0: return $urandom_range(3) == 0 ? QMax : QMin;
      1: return 32'sd0;
      2: return $signed($urandom_range(8) << 16) - 32'sd262144;
      3: return $signed($urandom_range(65535)) - 32'sd32768;
      default: return $signed($urandom);
    endcase
  endfunction

  task automatic wait_drained();
    req.valid <= 1'b0;
    while (pending_replies.size() != 0) @(negedge clk);
    repeat (80) @(negedge clk);
  endtask

  // receiver ready, random stalls and one long hold-off
  always @(negedge clk) begin
    if (rst) begin
      rsp.ready <= 1'b0;
      hold_cycles <= 0;
      hold_taken <= 1'b0;
    end else if (hold_req && !hold_taken) begin
      rsp.ready <= 1'b0;
      hold_cycles <= HoldLen;
      hold_taken <= 1'b1;
    end else if (hold_cycles > 0) begin
      rsp.ready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else rsp.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // reply checker
  always @(posedge clk) begin
    reply_t e;
    if (!rst && rsp.valid && rsp.ready) begin
      if (pending_replies.size() == 0) begin
        $display("%0t: unexpected reply status=%0d depth=%0d top=%h", $time,
                 rsp.status, rsp.depth_now, rsp.top_value);
        failed = 1'b1;
      end else begin
        e = pending_replies.pop_front();
        if (rsp.status !== e.status || rsp.saturated !== e.saturated ||
            rsp.depth_now !== e.depth_now || rsp.top_value !== e.top_value) begin
          $display("%0t: expected st=%0d sat=%0d depth=%0d top=%h, got st=%0d sat=%0d depth=%0d top=%h",
                   $time, e.status, e.saturated, e.depth_now, e.top_value,
                   rsp.status, rsp.saturated, rsp.depth_now, rsp.top_value);
          failed = 1'b1;
        end
      end
    end
  end

  // underflow, overflow, unused codes and corner arithmetic
  task automatic test_directed();
    send_cmd(CMD_ADD, 32'sd0);
    send_cmd(CMD_PUSH, 32'sd5);
    send_cmd(CMD_DIV, 32'sd0);
    send_cmd(3'd5, 32'sd1);
    send_cmd(3'd7, -32'sd1);
    send_cmd(CMD_PUSH, QMax);
    send_cmd(CMD_PUSH, QMax);
    send_cmd(CMD_ADD, 32'sd0);
    send_cmd(CMD_PUSH, QMin);
    send_cmd(CMD_SUB, 32'sd0);
    send_cmd(CMD_PUSH, -32'sd65536);
    send_cmd(CMD_MUL, 32'sd0);
    send_cmd(CMD_PUSH, 32'sd0);
    send_cmd(CMD_PUSH, 32'sd0);
    send_cmd(CMD_DIV, 32'sd0);
    send_cmd(CMD_PUSH, 32'sd0);
    send_cmd(CMD_PUSH, -32'sd3);
    send_cmd(CMD_DIV, 32'sd0);
    send_cmd(CMD_PUSH, 32'sd3);
    send_cmd(CMD_PUSH, -32'sd7);
    send_cmd(CMD_MUL, 32'sd0);
    send_cmd(CMD_PUSH, 32'sd1);
    send_cmd(CMD_DIV, 32'sd0);
  endtask

  // fill to full and push beyond, then operate down past empty, under a long reply hold-off
  task automatic test_overflow();
    hold_req = 1'b1;
    repeat (Depth + 2) send_cmd(CMD_PUSH, rand_value());
    repeat (Depth + 1) send_cmd(3'($urandom_range(CMD_ADD, CMD_DIV)), 32'sd0);
  endtask

  // random mix, mostly pushes and operations on a well-populated stack
  task automatic test_random(input int count);
    logic [2:0] c;
    repeat (count) begin
      if (calc_ptr < 3 && $urandom_range(3) != 0) c = CMD_PUSH;
      else if ($urandom_range(19) == 0) c = 3'($urandom_range(5, 7));
      else if ($urandom_range(2) == 0) c = CMD_PUSH;
      else c = 3'($urandom_range(CMD_ADD, CMD_DIV));
      send_cmd(c, rand_value());
    end
  endtask

  initial begin
    req.valid = 1'b0;
    req.cmd = CMD_PUSH;
    req.push_value = '0;
    send_idle_pct = 10;
    recv_idle_pct = 54;
    hold_req = 1'b0;
    calc_ptr = 0;
    foreach (calc_stack[i]) calc_stack[i] = '0;
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_overflow();
    test_random(100);
    send_idle_pct = 54;
    recv_idle_pct = 10;
    test_random(100);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(150);
    wait_drained();
    if (!failed) $display("rpn_stack_calculator: match");
    else $display("rpn_stack_calculator: mismatch");
    $finish;
  end

  // run limit
  initial begin
    #20ms;
    $display("rpn_stack_calculator: mismatch");
    $finish;
  end
endmodule

### rpn_stack_calculator.f
hw/rtl/rpn_pkg.sv
hw/rtl/rpn_if.sv
hw/rtl/rpn_ram.sv
hw/rtl/rpn_div.sv
hw/rtl/rpn_dp.sv
hw/rtl/rpn_ctrl.sv
hw/rtl/rpn_stack_calculator.sv
test/rpn_tb_if.sv
test/testbench.sv
